// File: rtl/core/scancode_set1_to_ascii_decoder_macros.svh
// Assertion macros for the scancode decoder.
`ifndef SCANCODE_SET1_TO_ASCII_DECODER_MACROS_SVH
`define SCANCODE_SET1_TO_ASCII_DECODER_MACROS_SVH

`ifndef SYNTH
`define SCS1A_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scs1a assertion failed");
`define SCS1A_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scs1a assertion failed");
`else
`define SCS1A_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SCS1A_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: rtl/core/scs1a_pkg.sv
`default_nettype none
package scs1a_pkg;

  localparam int TABLE_ENTRIES_DEF = 88;
  localparam int FLAG_DEPTH = 1;

  localparam logic [7:0] SCAN_PREFIX = 8'hE0;
  localparam logic [6:0] KEY_LSHIFT  = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT  = 7'h36;
  localparam logic [6:0] KEY_CTRL    = 7'h1D;
  localparam logic [6:0] KEY_LEFT    = 7'h4B;
  localparam logic [6:0] KEY_RIGHT   = 7'h4D;
  localparam logic [6:0] KEY_UP      = 7'h48;
  localparam logic [6:0] KEY_DOWN    = 7'h50;
  localparam logic [6:0] KEY_HOME    = 7'h47;
  localparam logic [6:0] KEY_END     = 7'h4F;
  localparam logic [6:0] KEY_DELETE  = 7'h53;

  localparam logic [7:0] NAV_LEFT   = 8'h81;
  localparam logic [7:0] NAV_RIGHT  = 8'h82;
  localparam logic [7:0] NAV_UP     = 8'h83;
  localparam logic [7:0] NAV_DOWN   = 8'h84;
  localparam logic [7:0] NAV_HOME   = 8'h85;
  localparam logic [7:0] NAV_END    = 8'h86;
  localparam logic [7:0] NAV_DELETE = 8'h87;
  localparam logic [7:0] NAV_NONE   = 8'h00;

  localparam logic [7:0] CHAR_A = 8'h61;
  localparam logic [7:0] CHAR_Z = 8'h7A;

  typedef struct packed {
    logic shift;
    logic ctrl;
    logic ext;
  } flags_t;

  localparam int FLAG_W = $bits(flags_t);

  typedef struct packed {
    logic       valid;
    logic [7:0] code;
  } result_t;

  function automatic logic [7:0] nav_code(input logic [6:0] key);
    logic [7:0] code;
    case (key)
      KEY_LEFT:   code = NAV_LEFT;
      KEY_RIGHT:  code = NAV_RIGHT;
      KEY_UP:     code = NAV_UP;
      KEY_DOWN:   code = NAV_DOWN;
      KEY_HOME:   code = NAV_HOME;
      KEY_END:    code = NAV_END;
      KEY_DELETE: code = NAV_DELETE;
      default:    code = NAV_NONE;
    endcase
    return code;
  endfunction

  // {plain, shifted} character for a make code
  function automatic logic [15:0] key_chars(input logic [6:0] key);
    logic [15:0] pair;
    case (key)
      7'd1:    pair = {8'h1B, 8'h1B};
      7'd2:    pair = {8'h31, 8'h21};
      7'd3:    pair = {8'h32, 8'h40};
      7'd4:    pair = {8'h33, 8'h23};
      7'd5:    pair = {8'h34, 8'h24};
      7'd6:    pair = {8'h35, 8'h25};
      7'd7:    pair = {8'h36, 8'h5E};
      7'd8:    pair = {8'h37, 8'h26};
      7'd9:    pair = {8'h38, 8'h2A};
      7'd10:   pair = {8'h39, 8'h28};
      7'd11:   pair = {8'h30, 8'h29};
      7'd12:   pair = {8'h2D, 8'h5F};
      7'd13:   pair = {8'h3D, 8'h2B};
      7'd14:   pair = {8'h08, 8'h08};
      7'd15:   pair = {8'h09, 8'h09};
      7'd16:   pair = {8'h71, 8'h51};
      7'd17:   pair = {8'h77, 8'h57};
      7'd18:   pair = {8'h65, 8'h45};
      7'd19:   pair = {8'h72, 8'h52};
      7'd20:   pair = {8'h74, 8'h54};
      7'd21:   pair = {8'h79, 8'h59};
      7'd22:   pair = {8'h75, 8'h55};
      7'd23:   pair = {8'h69, 8'h49};
      7'd24:   pair = {8'h6F, 8'h4F};
      7'd25:   pair = {8'h70, 8'h50};
      7'd26:   pair = {8'h5B, 8'h7B};
      7'd27:   pair = {8'h5D, 8'h7D};
      7'd28:   pair = {8'h0A, 8'h0A};
      7'd30:   pair = {8'h61, 8'h41};
      7'd31:   pair = {8'h73, 8'h53};
      7'd32:   pair = {8'h64, 8'h44};
      7'd33:   pair = {8'h66, 8'h46};
      7'd34:   pair = {8'h67, 8'h47};
      7'd35:   pair = {8'h68, 8'h48};
      7'd36:   pair = {8'h6A, 8'h4A};
      7'd37:   pair = {8'h6B, 8'h4B};
      7'd38:   pair = {8'h6C, 8'h4C};
      7'd39:   pair = {8'h3B, 8'h3A};
      7'd40:   pair = {8'h27, 8'h22};
      7'd41:   pair = {8'h60, 8'h7E};
      7'd43:   pair = {8'h5C, 8'h7C};
      7'd44:   pair = {8'h7A, 8'h5A};
      7'd45:   pair = {8'h78, 8'h58};
      7'd46:   pair = {8'h63, 8'h43};
      7'd47:   pair = {8'h76, 8'h56};
      7'd48:   pair = {8'h62, 8'h42};
      7'd49:   pair = {8'h6E, 8'h4E};
      7'd50:   pair = {8'h6D, 8'h4D};
      7'd51:   pair = {8'h2C, 8'h3C};
      7'd52:   pair = {8'h2E, 8'h3E};
      7'd53:   pair = {8'h2F, 8'h3F};
      7'd57:   pair = {8'h20, 8'h20};
      default: pair = 16'h0000;
    endcase
    return pair;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/scs1a_scan_if.sv
`default_nettype none
interface scs1a_scan_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink (input valid, input scan_byte, output ready);
endinterface
`default_nettype wire

// File: rtl/core/scs1a_char_if.sv
`default_nettype none
interface scs1a_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface
`default_nettype wire

// File: rtl/core/scs1a_ram.sv
`default_nettype none
module scs1a_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/core/scs1a_decode.sv
`default_nettype none
module scs1a_decode #(
  parameter int TABLE_ENTRIES = scs1a_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic [7:0]        scan_byte,
  input  wire scs1a_pkg::flags_t cur,
  output scs1a_pkg::flags_t      next,
  output scs1a_pkg::result_t     res
);
  import scs1a_pkg::*;

  localparam logic [7:0] TABLE_LIMIT = 8'(TABLE_ENTRIES);

  logic [6:0]  key;
  logic [15:0] pair;
  logic [7:0]  plain;
  logic [7:0]  shifted;
  logic [7:0]  nav;

  assign key     = scan_byte[6:0];
  assign pair    = key_chars(key);
  assign plain   = pair[15:8];
  assign shifted = pair[7:0];
  assign nav     = nav_code(key);

  always_comb begin
    next      = cur;
    res.valid = 1'b0;
    res.code  = 8'h00;
    if (scan_byte == SCAN_PREFIX) begin
      next.ext = 1'b1;
    end else if (scan_byte[7]) begin
      if (key == KEY_LSHIFT || key == KEY_RSHIFT) begin
        next.shift = 1'b0;
      end
      if (key == KEY_CTRL) begin
        next.ctrl = 1'b0;
      end
      next.ext = 1'b0;
    end else if (key == KEY_LSHIFT || key == KEY_RSHIFT) begin
      next.shift = 1'b1;
    end else if (key == KEY_CTRL && !cur.ext) begin
      next.ctrl = 1'b1;
    end else if (cur.ext) begin
      next.ext  = 1'b0;
      res.code  = nav;
      res.valid = (nav != NAV_NONE);
    end else if (scan_byte < TABLE_LIMIT) begin
      if (cur.ctrl) begin
        if (plain inside {[CHAR_A:CHAR_Z]}) begin
          res.valid = 1'b1;
          res.code  = 8'(plain - CHAR_A + 8'd1);
        end
      end else begin
        res.code  = cur.shift ? shifted : plain;
        res.valid = (res.code != 8'h00);
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/scancode_set1_to_ascii_decoder.sv
// Channel  Dir  Payload           Transfer
// scan     in   scan_byte [7:0]   valid & ready
// result   out  char_code [7:0]   valid & ready
//
// One scancode per cycle unless a stalled result holds the decode stage.
// Key flags live in a one-entry RAM read every cycle; the value written on
// the previous edge is forwarded, as the registered RAM read does not yet show it.
// Reset clears a valid bit for the flag entry, so no clearing pass is needed.
// A stalled result holds the decode stage only if that request yields a code.
`default_nettype none
`include "scancode_set1_to_ascii_decoder_macros.svh"
module scancode_set1_to_ascii_decoder #(
  parameter int TABLE_ENTRIES = scs1a_pkg::TABLE_ENTRIES_DEF
) (
  input wire logic    clk,
  input wire logic    rst,
  scs1a_scan_if.sink  scan,
  scs1a_char_if.source result
);
  import scs1a_pkg::*;

  localparam int AW = (FLAG_DEPTH > 1) ? $clog2(FLAG_DEPTH) : 1;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       state_valid;
  logic       fresh;
  flags_t     flags_last;
  flags_t     flags_rd;
  flags_t     flags_cur;
  flags_t     flags_next;
  result_t    dec_res;
  logic       out_valid;
  logic [7:0] out_code;
  logic       out_free;
  logic       advance;
  logic       ctrl_hit;

  scs1a_ram #(
    .WIDTH(FLAG_W),
    .DEPTH(FLAG_DEPTH)
  ) u_flags (
    .clk   (clk),
    .we    (advance),
    .waddr ({AW{1'b0}}),
    .wdata (flags_next),
    .raddr ({AW{1'b0}}),
    .rdata (flags_rd)
  );

  always_comb begin
    if (fresh) begin
      flags_cur = flags_last;
    end else if (state_valid) begin
      flags_cur = flags_rd;
    end else begin
      flags_cur = '0;
    end
  end

  scs1a_decode #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_decode (
    .scan_byte (s1_byte),
    .cur       (flags_cur),
    .next      (flags_next),
    .res       (dec_res)
  );

  assign out_free   = !out_valid || result.ready;
  assign advance    = s1_valid && (!dec_res.valid || out_free);
  assign scan.ready = !s1_valid || advance;
  assign ctrl_hit   = advance && dec_res.valid && flags_cur.ctrl && !flags_cur.ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      state_valid <= 1'b0;
      fresh       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (scan.ready) begin
        s1_valid <= scan.valid;
      end
      if (advance) begin
        state_valid <= 1'b1;
      end
      fresh <= advance;
      if (advance && dec_res.valid) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan.valid && scan.ready) begin
      s1_byte <= scan.scan_byte;
    end
    if (advance) begin
      flags_last <= flags_next;
    end
    if (advance && dec_res.valid) begin
      out_code <= dec_res.code;
    end
  end

  assign result.valid     = out_valid;
  assign result.char_code = out_code;

  `SCS1A_ASSERT_IMPL(a_out_nonzero, clk, rst, out_valid, out_code != 8'h00)
  `SCS1A_ASSERT_NEXT(a_prefix_arms, clk, rst, advance && s1_byte == SCAN_PREFIX, flags_last.ext)
  `SCS1A_ASSERT_IMPL(a_ctrl_range, clk, rst, ctrl_hit, dec_res.code >= 8'd1 && dec_res.code <= 8'd26)
  `SCS1A_ASSERT_IMPL(a_no_overrun, clk, rst, advance && dec_res.valid, out_free)

endmodule
`default_nettype wire

// File: dv/scancode_set1_to_ascii_decoder_tb.sv
`timescale 1ns / 1ps
module scancode_set1_to_ascii_decoder_tb;
  import scs1a_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RANDOM_SCANS = 1550;
  localparam int KEY_ROWS     = 58;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 6;

  logic clk = 1'b0;
  logic rst;

  scs1a_scan_if scan_bus ();
  scs1a_char_if char_bus ();

  scancode_set1_to_ascii_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .scan   (scan_bus),
    .result (char_bus)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  logic [7:0] plain_row [KEY_ROWS] = '{
    8'h00, 8'h1B, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=",
    8'h08, 8'h09,
    "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]",
    8'h0A, 8'h00,
    "a", "s", "d", "f", "g", "h", "j", "k", "l", ";", 8'h27,
    8'h60, 8'h00, 8'h5C,
    "z", "x", "c", "v", "b", "n", "m", ",", ".", "/",
    8'h00, 8'h00, 8'h00, " "
  };

  logic [7:0] shifted_row [KEY_ROWS] = '{
    8'h00, 8'h1B, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+",
    8'h08, 8'h09,
    "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}",
    8'h0A, 8'h00,
    "A", "S", "D", "F", "G", "H", "J", "K", "L", ":", 8'h22,
    "~", 8'h00, "|",
    "Z", "X", "C", "V", "B", "N", "M", "<", ">", "?",
    8'h00, 8'h00, 8'h00, " "
  };

  logic       shift_down = 1'b0;
  logic       ctrl_down  = 1'b0;
  logic       ext_armed  = 1'b0;
  logic [7:0] expected_chars [$];
  int         mismatches   = 0;
  int         scans_sent   = 0;
  int         quiet_cycles = 0;
  int         stall_left   = 0;
  bit         scan_calm    = 1'b0;
  bit         sink_calm    = 1'b0;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 93) return $urandom_range(3, 6);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [6:0] pick_nav_key();
    case ($urandom_range(0, 6))
      0: return KEY_LEFT;
      1: return KEY_RIGHT;
      2: return KEY_UP;
      3: return KEY_DOWN;
      4: return KEY_HOME;
      5: return KEY_END;
      default: return KEY_DELETE;
    endcase
  endfunction

  task automatic decode_scan(input logic [7:0] code);
    logic [6:0] key;
    logic [7:0] ch;
    logic       is_shift;
    key = code[6:0];
    ch = 8'h00;
    is_shift = (key == KEY_LSHIFT) || (key == KEY_RSHIFT);
    if (code == SCAN_PREFIX) begin
      ext_armed = 1'b1;
    end else if (code[7]) begin
      if (is_shift) shift_down = 1'b0;
      if (key == KEY_CTRL) ctrl_down = 1'b0;
      ext_armed = 1'b0;
    end else if (is_shift) begin
      shift_down = 1'b1;
    end else if (key == KEY_CTRL && !ext_armed) begin
      ctrl_down = 1'b1;
    end else if (ext_armed) begin
      ext_armed = 1'b0;
      case (key)
        KEY_LEFT:   ch = NAV_LEFT;
        KEY_RIGHT:  ch = NAV_RIGHT;
        KEY_UP:     ch = NAV_UP;
        KEY_DOWN:   ch = NAV_DOWN;
        KEY_HOME:   ch = NAV_HOME;
        KEY_END:    ch = NAV_END;
        KEY_DELETE: ch = NAV_DELETE;
        default:    ch = NAV_NONE;
      endcase
    end else if (int'(key) < TABLE_ENTRIES_DEF && int'(key) < KEY_ROWS) begin
      if (ctrl_down) begin
        if (plain_row[key] >= CHAR_A && plain_row[key] <= CHAR_Z)
          ch = plain_row[key] - CHAR_A + 8'd1;
      end else begin
        ch = shift_down ? shifted_row[key] : plain_row[key];
      end
    end
    if (ch != 8'h00) expected_chars.push_back(ch);
  endtask

  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst) begin
      if (char_bus.valid === 1'b1 && char_bus.ready === 1'b1) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: char_code expected none actual %h", $time, char_bus.char_code);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          if (char_bus.char_code !== want) begin
            $display("%0t: char_code expected %h actual %h", $time, want,
                     char_bus.char_code);
            mismatches++;
          end
        end
      end
      if (scan_bus.valid === 1'b1 && scan_bus.ready === 1'b1)
        decode_scan(scan_bus.scan_byte);
    end
  end

  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) sink_calm = !sink_calm;
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      char_bus.ready <= 1'b0;
    end else if (!sink_calm && $urandom_range(0, 3) == 0) begin
      stall_left = idle_len() - 1;
      char_bus.ready <= 1'b0;
    end else begin
      char_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (scan_bus.valid === 1'b1 && scan_bus.ready === 1'b1) ||
        (char_bus.valid === 1'b1 && char_bus.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_scan(input logic [7:0] code);
    int gap;
    if ($urandom_range(0, 99) == 0) scan_calm = !scan_calm;
    gap = (scan_calm || $urandom_range(0, 2) != 0) ? 0 : idle_len();
    if (gap > 0) begin
      scan_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    scan_bus.valid <= 1'b1;
    scan_bus.scan_byte <= code;
    @(posedge clk);
    while (scan_bus.ready !== 1'b1) @(posedge clk);
    scans_sent++;
  endtask

  task automatic test_plain_keys();
    send_scan(8'h00);
    send_scan(8'h01);
    send_scan(8'h39);
    send_scan(8'h58);
    send_scan(8'h7F);
  endtask

  task automatic test_shift_keys();
    send_scan({1'b0, KEY_LSHIFT});
    send_scan(8'h10);
    send_scan(8'h02);
    send_scan({1'b1, KEY_LSHIFT});
  endtask

  task automatic test_ctrl_keys();
    send_scan({1'b0, KEY_CTRL});
    send_scan(8'h1E);
    send_scan(8'h2C);
    send_scan({1'b1, KEY_CTRL});
  endtask

  task automatic test_extended_keys();
    send_scan(SCAN_PREFIX);
    send_scan({1'b0, KEY_LEFT});
    send_scan(SCAN_PREFIX);
    send_scan({1'b0, KEY_DELETE});
    // right ctrl: consumes the prefix, does not hold ctrl
    send_scan(SCAN_PREFIX);
    send_scan({1'b0, KEY_CTRL});
    send_scan(8'h1E);
    // shift after the prefix keeps it armed
    send_scan(SCAN_PREFIX);
    send_scan({1'b0, KEY_LSHIFT});
    send_scan({1'b0, KEY_RIGHT});
    send_scan({1'b1, KEY_LSHIFT});
    // a release drops the prefix
    send_scan(SCAN_PREFIX);
    send_scan(8'h9E);
    send_scan(8'h10);
    send_scan(8'hFF);
  endtask

  task automatic test_random_typing();
    int         target;
    int         r;
    logic [6:0] key;
    target = scans_sent + RANDOM_SCANS;
    while (scans_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        key = 7'($urandom_range(0, KEY_ROWS - 1));
        send_scan({1'b0, key});
        if ($urandom_range(0, 1) == 0) send_scan({1'b1, key});
      end else if (r < 55) begin
        case ($urandom_range(0, 2))
          0: key = KEY_LSHIFT;
          1: key = KEY_RSHIFT;
          default: key = KEY_CTRL;
        endcase
        send_scan({$urandom_range(0, 1) == 1, key});
      end else if (r < 75) begin
        key = ($urandom_range(0, 9) < 7) ? pick_nav_key() : 7'($urandom_range(0, 127));
        send_scan(SCAN_PREFIX);
        send_scan({1'b0, key});
        if ($urandom_range(0, 1) == 0) begin
          send_scan(SCAN_PREFIX);
          send_scan({1'b1, key});
        end
      end else if (r < 85) begin
        send_scan(8'($urandom_range(KEY_ROWS, 127)));
      end else begin
        send_scan(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    scan_bus.valid <= 1'b0;
    scan_bus.scan_byte <= 8'h00;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_plain_keys();
    test_shift_keys();
    test_ctrl_keys();
    test_extended_keys();
    test_random_typing();

    scan_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/scs1a_pkg.sv
rtl/core/scs1a_scan_if.sv
rtl/core/scs1a_char_if.sv
rtl/core/scs1a_ram.sv
rtl/core/scs1a_decode.sv
rtl/core/scancode_set1_to_ascii_decoder.sv
dv/scancode_set1_to_ascii_decoder_tb.sv
